[src/ietm_pkg.sv]
// Package for the IFD entry tag matcher.
// Holds the shared types, register index codes and format helpers; no dependencies.
package ietm_pkg;

   localparam int WANTED_REGS = 4;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 48;
   localparam int SIZE_W      = 19;
   localparam logic [31:0] MAX_COUNT    = 32'h0000_ffff;
   localparam logic [15:0] ENTRY_BYTES  = 16'h000c;
   localparam logic [15:0] ENTRY_SKIP   = 16'h0002;
   localparam logic [31:0] VALUE_POS    = 32'h0000_0008;
   localparam logic [19:0] INLINE_LIMIT = 20'd4;
   localparam logic [15:0] FORMAT_KINDS = 16'd12;
   localparam logic [15:0] BASE_RESET   = 16'h0008;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LITTLE_ENDIAN  = 8'd0,
      CSR_DIRECTORY_BASE = 8'd1,
      CSR_SLOTS_IN_USE   = 8'd2,
      CSR_WANTED_A       = 8'd3,
      CSR_WANTED_B       = 8'd4,
      CSR_WANTED_C       = 8'd5,
      CSR_WANTED_D       = 8'd6
   } csr_index_type;

   typedef struct packed {
      logic                             little_endian;
      logic [15:0]                      directory_base;
      logic [2:0]                       slots_in_use;
      logic [WANTED_REGS-1:0][47:0]     wanted;
   } cfg_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [15:0] fmt;
      logic [31:0] cnt;
      logic [31:0] val;
      logic [15:0] pos;
   } entry_type;

   typedef struct packed {
      logic              hit;
      logic [1:0]        slot_hit;
      logic [31:0]       data_offset;
      logic [SIZE_W-1:0] data_size;
   } match_type;

   function automatic logic [15:0] swap16(input logic [15:0] v);
      return {v[7:0], v[15:8]};
   endfunction

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   // bytes per component; 0 for an unknown format
   function automatic logic [3:0] fmt_size(input logic [15:0] fmt);
      logic [3:0] sz;
      case (fmt)
         16'd1, 16'd2, 16'd6, 16'd7: sz = 4'd1;
         16'd3, 16'd8:               sz = 4'd2;
         16'd4, 16'd9, 16'd11:       sz = 4'd4;
         16'd5, 16'd10, 16'd12:      sz = 4'd8;
         default:                    sz = 4'd0;
      endcase
      return sz;
   endfunction

endpackage

[src/ietm_if.sv]
// Channel interfaces of the IFD entry tag matcher: request, response, register write.
// Depends on ietm_pkg for the register index and data widths.
interface ietm_req_if;
   logic        valid;
   logic        ready;
   logic        first_entry;
   logic [15:0] raw_tag;
   logic [15:0] raw_format;
   logic [31:0] raw_components;
   logic [31:0] raw_value;
   modport source (output valid, first_entry, raw_tag, raw_format, raw_components,
                   raw_value, input ready);
   modport sink (input valid, first_entry, raw_tag, raw_format, raw_components,
                 raw_value, output ready);
endinterface

interface ietm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  slot_hit;
   logic [31:0] data_offset;
   logic [18:0] data_size;
   modport source (output valid, slot_hit, data_offset, data_size, input ready);
   modport sink (input valid, slot_hit, data_offset, data_size, output ready);
endinterface

interface ietm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ietm_pkg::CSR_INDEX_W-1:0] index;
   logic [ietm_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[src/ietm_csr.sv]
// Configuration registers of the IFD entry tag matcher.
// Depends on ietm_pkg and the ietm_csr_if write channel.
module ietm_csr (
   input  logic            clock,
   input  logic            reset,
   ietm_csr_if.sink        csr,
   output ietm_pkg::cfg_type cfg
);
   import ietm_pkg::*;

   logic                         little_endian_ff;
   logic [15:0]                  directory_base_ff;
   logic [2:0]                   slots_in_use_ff;
   logic [WANTED_REGS-1:0][47:0] wanted_ff;
   logic [CSR_INDEX_W-1:0]       wanted_sel;

   assign csr.ready  = 1'b1;
   assign wanted_sel = csr.index - CSR_WANTED_A;

   always_ff @(posedge clock) begin
      if (reset) begin
         little_endian_ff  <= 1'b0;
         directory_base_ff <= BASE_RESET;
         slots_in_use_ff   <= 3'd0;
         wanted_ff         <= '0;
      end else if (csr.valid) begin
         unique case (csr.index) inside
            CSR_LITTLE_ENDIAN:  little_endian_ff  <= csr.data[0];
            CSR_DIRECTORY_BASE: directory_base_ff <= csr.data[15:0];
            CSR_SLOTS_IN_USE:   slots_in_use_ff   <= csr.data[2:0];
            CSR_WANTED_A, CSR_WANTED_B, CSR_WANTED_C, CSR_WANTED_D:
               wanted_ff[wanted_sel[1:0]] <= csr.data[47:0];
            default: ;
         endcase
      end
   end

   assign cfg.little_endian  = little_endian_ff;
   assign cfg.directory_base = directory_base_ff;
   assign cfg.slots_in_use   = slots_in_use_ff;
   assign cfg.wanted         = wanted_ff;

endmodule

[src/ietm_match.sv]
// Tag compare, format check and size/offset computation for one registered entry.
// Depends on ietm_pkg.
module ietm_match #(
   parameter int TAG_SLOTS = 4
) (
   input  ietm_pkg::cfg_type   cfg,
   input  ietm_pkg::entry_type entry,
   output ietm_pkg::match_type result
);
   import ietm_pkg::*;

   logic [TAG_SLOTS-1:0][47:0] slot_word;
   logic [15:0] tag;
   logic [15:0] fmt;
   logic [31:0] cnt;
   logic [31:0] val;
   logic        found;
   logic [2:0]  sel;
   logic [47:0] w;
   logic [3:0]  sz;
   logic [19:0] prod;
   logic        ok;

   // slots without a register stay zero
   for (genvar g = 0; g < TAG_SLOTS; g++) begin : g_slot
      if (g < WANTED_REGS) begin : g_reg
         assign slot_word[g] = cfg.wanted[g];
      end else begin : g_zero
         assign slot_word[g] = '0;
      end
   end

   always_comb begin
      tag = cfg.little_endian ? swap16(entry.tag) : entry.tag;
      fmt = cfg.little_endian ? swap16(entry.fmt) : entry.fmt;
      cnt = cfg.little_endian ? swap32(entry.cnt) : entry.cnt;
      val = cfg.little_endian ? swap32(entry.val) : entry.val;

      found = 1'b0;
      sel   = 3'd0;
      w     = '0;
      for (int s = 0; s < TAG_SLOTS; s++) begin
         if (!found && (4'(s) < {1'b0, cfg.slots_in_use}) && slot_word[s][47:32] == tag) begin
            found = 1'b1;
            sel   = 3'(s);
            w     = slot_word[s];
         end
      end

      sz   = fmt_size(fmt);
      prod = 20'(sz) * 20'(cnt[15:0]);
      ok   = found && (w[31:16] == fmt) && (cnt < MAX_COUNT) &&
             (w[15:0] == 16'd0 || w[15:0] == cnt[15:0]) && (sz != 4'd0);

      result.hit         = ok;
      result.slot_hit    = sel[1:0];
      result.data_offset = (prod <= INLINE_LIMIT) ? (32'(entry.pos) + VALUE_POS) : val;
      result.data_size   = prod[SIZE_W-1:0];
   end

endmodule

[src/ifd_entry_tag_matcher_top.sv]
// Top level of the IFD entry tag matcher: entry register, entry index, result register.
// Depends on ietm_pkg, ietm_if, ietm_csr and ietm_match.
//
// Usage:
//   req_chan carries one 12-byte directory entry per request, fields in file
//   byte order. first_entry restarts the entry index for a new directory.
//   rsp_chan returns slot, data offset and data size for entries that match a
//   wanted slot; other entries produce no response.
//   csr_chan writes the configuration registers and is always ready; the user
//   must see that it is written only while no request is in flight (not enforced).
// Pipeline: an accepted request is held in the entry register and matched there;
//   its response is loaded into the result register (two registers: entry, result).
// Throughput: one request per cycle while no stall holds the entry register; the
//   compare and 4x16 size multiply between the two registers are combinational.
// Stall: while rsp_chan is held off with a response waiting, a matching entry
//   waits in the entry register and req_chan.ready drops; entries that miss
//   are dropped without waiting.
// Reset: synchronous; clears both valid flags and the entry index and loads
//   register reset values (directory_base 8, everything else zero).
module ifd_entry_tag_matcher_top #(
   parameter int TAG_SLOTS = 4
) (
   input logic        clock,
   input logic        reset,
   ietm_req_if.sink   req_chan,
   ietm_rsp_if.source rsp_chan,
   ietm_csr_if.sink   csr_chan
);
   import ietm_pkg::*;

   cfg_type   cfg;
   match_type match_res;

   logic        s1_valid_ff, s1_valid_in;
   entry_type   s1_entry_ff;
   logic [15:0] entry_index_ff, entry_index_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_slot_ff;
   logic [31:0] rsp_offset_ff;
   logic [SIZE_W-1:0] rsp_size_ff;

   logic        req_acc;
   logic        out_free;
   logic        s1_done;
   logic        rsp_load;
   logic [15:0] idx_used;

   ietm_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .cfg   (cfg)
   );

   ietm_match #(.TAG_SLOTS(TAG_SLOTS)) u_match (
      .cfg    (cfg),
      .entry  (s1_entry_ff),
      .result (match_res)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load       = s1_valid_ff && match_res.hit && out_free;
   assign s1_done        = s1_valid_ff && (!match_res.hit || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_done;
   assign req_acc        = req_chan.valid && req_chan.ready;

   assign idx_used       = req_chan.first_entry ? 16'd0 : entry_index_ff;
   assign entry_index_in = req_acc ? idx_used + 16'd1 : entry_index_ff;
   assign s1_valid_in    = req_acc ? 1'b1 : (s1_done ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in   = rsp_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_index_ff <= 16'd0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         entry_index_ff <= entry_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_entry_ff.tag <= req_chan.raw_tag;
         s1_entry_ff.fmt <= req_chan.raw_format;
         s1_entry_ff.cnt <= req_chan.raw_components;
         s1_entry_ff.val <= req_chan.raw_value;
         s1_entry_ff.pos <= (idx_used << 3) + (idx_used << 2) + ENTRY_SKIP +
                            cfg.directory_base;
      end
      if (rsp_load) begin
         rsp_slot_ff   <= match_res.slot_hit;
         rsp_offset_ff <= match_res.data_offset;
         rsp_size_ff   <= match_res.data_size;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.slot_hit    = rsp_slot_ff;
   assign rsp_chan.data_offset = rsp_offset_ff;
   assign rsp_chan.data_size   = rsp_size_ff;

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_chan.valid && !s1_valid_ff)
      else $error("valid flags not cleared by reset");
   a_index_restart: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_chan.first_entry |=> entry_index_ff == 16'd1)
      else $error("entry index did not restart");
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      req_acc && !req_chan.first_entry |=> entry_index_ff == $past(entry_index_ff) + 16'd1)
      else $error("entry index did not advance");
   a_entry_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_done |=> s1_valid_ff && $stable(s1_entry_ff))
      else $error("waiting entry lost or changed");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_chan.valid || rsp_chan.ready)
      else $error("pending response overwritten");
`endif

endmodule

[dv/testbench.sv]
// Self-checking bench for ifd_entry_tag_matcher_top: directed and random directory entries.
// A scoreboard class predicts matches from its own register copy and checks each response.
// Depends on ietm_pkg, ietm_if and the matcher RTL.
`timescale 1ns / 100ps

module testbench;
   import ietm_pkg::*;

   localparam int SLOT_COUNT      = 4;
   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 12;
   localparam int DRAIN_CYCLES    = 6;
   localparam int HOLD_CYCLES     = 300;
   localparam int IDLE_PERCENT    = 26;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 230;
   localparam int CYCLE_LIMIT     = 600000;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAST_END  = CSR_INDEX_W'(CSR_WANTED_D) + 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_INDEX = '1;

   typedef struct packed {
      logic [1:0]  slot_hit;
      logic [31:0] data_offset;
      logic [18:0] data_size;
   } entry_match_type;

   class entry_match_scoreboard_type;
      logic              little_endian;
      logic [15:0]       directory_base;
      logic [2:0]        slots_in_use;
      logic [47:0]       wanted [SLOT_COUNT];
      logic [15:0]       entry_index;
      int unsigned       bytes_per_component [12] = '{1, 1, 2, 4, 8, 1, 1, 2, 4, 8, 4, 8};
      entry_match_type   expected_matches [$];
      int                errors;

      function new();
         little_endian  = 1'b0;
         directory_base = BASE_RESET;
         slots_in_use   = '0;
         foreach (wanted[i]) wanted[i] = '0;
         entry_index    = '0;
         errors         = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_LITTLE_ENDIAN:  little_endian  = data[0];
            CSR_DIRECTORY_BASE: directory_base = data[15:0];
            CSR_SLOTS_IN_USE:   slots_in_use   = data[2:0];
            CSR_WANTED_A, CSR_WANTED_B, CSR_WANTED_C, CSR_WANTED_D:
               wanted[int'(idx) - int'(CSR_WANTED_A)] = data[47:0];
            default: ;
         endcase
      endfunction

      function void predict_match(logic first, logic [15:0] raw_tag, logic [15:0] raw_fmt,
                                  logic [31:0] raw_cnt, logic [31:0] raw_val);
         logic [15:0]     idx, pos, tag, fmt;
         logic [31:0]     cnt, val, size;
         int              active, hit;
         entry_match_type m;
         idx = first ? 16'd0 : entry_index;
         entry_index = idx + 16'd1;
         pos = idx * ENTRY_BYTES + ENTRY_SKIP + directory_base;
         if (little_endian) begin
            tag = {<<8{raw_tag}};
            fmt = {<<8{raw_fmt}};
            cnt = {<<8{raw_cnt}};
            val = {<<8{raw_val}};
         end else begin
            tag = raw_tag;
            fmt = raw_fmt;
            cnt = raw_cnt;
            val = raw_val;
         end
         active = (slots_in_use > SLOT_COUNT) ? SLOT_COUNT : int'(slots_in_use);
         hit = -1;
         for (int s = 0; s < active; s++)
            if (hit < 0 && wanted[s][47:32] == tag) hit = s;
         if (hit < 0) return;
         if (wanted[hit][31:16] != fmt) return;
         if (cnt >= MAX_COUNT) return;
         if (wanted[hit][15:0] != 16'd0 && {16'd0, wanted[hit][15:0]} != cnt) return;
         if (fmt == 16'd0 || fmt > FORMAT_KINDS) return;
         size = bytes_per_component[int'(fmt) - 1] * cnt;
         m.slot_hit    = 2'(hit);
         m.data_offset = ({12'd0, size} <= INLINE_LIMIT) ? {16'd0, pos} + VALUE_POS : val;
         m.data_size   = size[18:0];
         expected_matches.push_back(m);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_response(logic [1:0] slot_hit, logic [31:0] data_offset,
                          logic [18:0] data_size);
         entry_match_type m;
         if (expected_matches.size() == 0) begin
            report($sformatf("response with none expected: slot %0d offset %h size %0d",
                             slot_hit, data_offset, data_size));
            return;
         end
         m = expected_matches.pop_front();
         if (slot_hit !== m.slot_hit)
            report($sformatf("slot_hit %0d, expected %0d", slot_hit, m.slot_hit));
         if (data_offset !== m.data_offset)
            report($sformatf("data_offset %h, expected %h", data_offset, m.data_offset));
         if (data_size !== m.data_size)
            report($sformatf("data_size %0d, expected %0d", data_size, m.data_size));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   idle_enable  = 1'b1;
   bit   hold_request = 1'b0;
   int   cycle_count  = 0;
   entry_match_scoreboard_type sb = new();

   ietm_req_if req_chan ();
   ietm_rsp_if rsp_chan ();
   ietm_csr_if csr_chan ();

   ifd_entry_tag_matcher_top #(.TAG_SLOTS(SLOT_COUNT)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // all handshakes are sampled mid-cycle, when every signal has settled
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_response(rsp_chan.slot_hit, rsp_chan.data_offset, rsp_chan.data_size);
         if (csr_chan.valid && csr_chan.ready)
            sb.write_register(csr_chan.index, csr_chan.data);
         if (req_chan.valid && req_chan.ready)
            sb.predict_match(req_chan.first_entry, req_chan.raw_tag, req_chan.raw_format,
                             req_chan.raw_components, req_chan.raw_value);
      end
   end

   initial begin : rsp_drive
      int hold_count;
      bit hold_done;
      hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= !idle_enable || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   task automatic send_entry(logic first, logic [15:0] tag, logic [15:0] fmt,
                             logic [31:0] cnt, logic [31:0] val);
      logic accepted;
      if (idle_enable) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid          <= 1'b1;
      req_chan.first_entry    <= first;
      req_chan.raw_tag        <= tag;
      req_chan.raw_format     <= fmt;
      req_chan.raw_components <= cnt;
      req_chan.raw_value      <= val;
      do begin
         @(negedge clock);
         accepted = req_chan.ready;
         @(posedge clock);
      end while (!accepted);
   endtask

   // fields given in host order; swapped into file order when the file is little endian
   task automatic send_logical(logic first, logic [15:0] tag, logic [15:0] fmt,
                               logic [31:0] cnt, logic [31:0] val);
      logic [15:0] ftag, ffmt;
      logic [31:0] fcnt, fval;
      if (sb.little_endian) begin
         ftag = {<<8{tag}};
         ffmt = {<<8{fmt}};
         fcnt = {<<8{cnt}};
         fval = {<<8{val}};
      end else begin
         ftag = tag;
         ffmt = fmt;
         fcnt = cnt;
         fval = val;
      end
      send_entry(first, ftag, ffmt, fcnt, fval);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      logic accepted;
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      do begin
         @(negedge clock);
         accepted = csr_chan.ready;
         @(posedge clock);
      end while (!accepted);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.expected_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_random_config(logic le, logic [15:0] base, logic [2:0] slots);
      logic [47:0] w;
      logic [15:0] tag, fmt, cnt;
      int          r;
      w = 48'({$urandom, $urandom});
      w[0] = le;
      write_csr(CSR_LITTLE_ENDIAN, w);
      w = 48'({$urandom, $urandom});
      w[15:0] = base;
      write_csr(CSR_DIRECTORY_BASE, w);
      w = 48'({$urandom, $urandom});
      w[2:0] = slots;
      write_csr(CSR_SLOTS_IN_USE, w);
      for (int s = 0; s < SLOT_COUNT; s++) begin
         tag = (s > 0 && $urandom_range(99) < 20) ? sb.wanted[s-1][47:32] : 16'($urandom);
         r = $urandom_range(99);
         if (r < 80)      fmt = 16'($urandom_range(1, 12));
         else if (r < 88) fmt = 16'd0;
         else if (r < 94) fmt = 16'($urandom_range(13, 16'hffff));
         else             fmt = 16'($urandom);
         r = $urandom_range(99);
         if (r < 45)      cnt = 16'd0;
         else if (r < 80) cnt = 16'($urandom_range(1, 8));
         else if (r < 90) cnt = 16'($urandom_range(16'hfffe, 16'hffff));
         else             cnt = 16'($urandom);
         write_csr(CSR_INDEX_W'(CSR_WANTED_A) + CSR_INDEX_W'(s), {tag, fmt, cnt});
      end
      write_csr(($urandom_range(1) != 0) ? CSR_PAST_END : CSR_TOP_INDEX,
                48'({$urandom, $urandom}));
   endtask

   // mostly well-formed entries aimed at a wanted slot, the rest broken or plain noise
   task automatic send_random_entry(bit allow_first);
      logic        first;
      logic [15:0] tag, fmt;
      logic [31:0] cnt, val;
      int          s, kind, r;
      first = allow_first && ($urandom_range(99) < 8);
      kind  = $urandom_range(99);
      s     = $urandom_range(SLOT_COUNT - 1);
      val   = $urandom;
      tag   = sb.wanted[s][47:32];
      fmt   = sb.wanted[s][31:16];
      r     = $urandom_range(99);
      if (sb.wanted[s][15:0] != 16'd0) cnt = {16'd0, sb.wanted[s][15:0]};
      else if (r < 70)                 cnt = $urandom_range(0, 8);
      else if (r < 85)                 cnt = $urandom_range(0, 16'hfffe);
      else                             cnt = $urandom_range(16'hfff0, 16'hfffe);
      if (kind < 60) begin
      end else if (kind < 70) begin
         fmt = ($urandom_range(1) != 0) ? fmt + 16'd1 : 16'($urandom);
      end else if (kind < 78) begin
         cnt = ($urandom_range(1) != 0) ? cnt + 32'd1 : $urandom;
      end else if (kind < 84) begin
         r = $urandom_range(2);
         if (r == 0)      cnt = MAX_COUNT + 32'($urandom_range(0, 3));
         else if (r == 1) cnt = 32'hffff_ffff;
         else             cnt = $urandom | 32'h0001_0000;
      end else begin
         tag = 16'($urandom);
         fmt = 16'($urandom);
         cnt = $urandom;
      end
      send_logical(first, tag, fmt, cnt, val);
   endtask

   initial begin : stimulus
      int phase;
      req_chan.valid          <= 1'b0;
      req_chan.first_entry    <= 1'b0;
      req_chan.raw_tag        <= '0;
      req_chan.raw_format     <= '0;
      req_chan.raw_components <= '0;
      req_chan.raw_value      <= '0;
      csr_chan.valid          <= 1'b0;
      csr_chan.index          <= '0;
      csr_chan.data           <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register reset values: no active slot, index still advances
      send_entry(1'b0, 16'h0112, 16'h0003, 32'd1, 32'h0);
      send_entry(1'b0, 16'h0000, 16'h0000, 32'd0, 32'h0);
      wait_drained();

      write_csr(CSR_LITTLE_ENDIAN,  48'd0);
      write_csr(CSR_DIRECTORY_BASE, 48'd8);
      write_csr(CSR_SLOTS_IN_USE,   48'd4);
      write_csr(CSR_WANTED_A, {16'h0112, 16'd3, 16'd1});
      write_csr(CSR_WANTED_B, {16'h8769, 16'd4, 16'd0});
      write_csr(CSR_WANTED_C, {16'hffff, 16'd12, 16'hfffe});
      write_csr(CSR_WANTED_D, {16'h0000, 16'd1, 16'd0});
      send_logical(1'b1, 16'h0112, 16'd3, 32'd1, 32'h1234_5678);
      send_logical(1'b0, 16'h8769, 16'd4, 32'd1, 32'hdead_beef);
      send_logical(1'b0, 16'h8769, 16'd4, 32'd2, 32'h0000_0100);
      send_logical(1'b0, 16'hffff, 16'd12, 32'h0000_fffe, 32'hffff_ffff);
      send_logical(1'b0, 16'h0000, 16'd1, 32'd0, 32'h0);
      send_logical(1'b0, 16'h0112, 16'd3, 32'd2, 32'h0);
      send_logical(1'b0, 16'h0112, 16'd4, 32'd1, 32'h0);
      send_logical(1'b0, 16'h8769, 16'd4, 32'h0000_ffff, 32'h0);
      send_logical(1'b0, 16'h8769, 16'd4, 32'hffff_ffff, 32'h0);
      send_logical(1'b0, 16'h1234, 16'd4, 32'd1, 32'h0);
      send_logical(1'b0, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
      send_logical(1'b1, 16'h8769, 16'd4, 32'd1, 32'h0);
      wait_drained();

      // little endian, top base, slot count above the slot limit, duplicate tag,
      // unknown formats
      write_csr(CSR_LITTLE_ENDIAN,  48'd1);
      write_csr(CSR_DIRECTORY_BASE, 48'hffff);
      write_csr(CSR_SLOTS_IN_USE,   48'd7);
      write_csr(CSR_WANTED_A, {16'h0100, 16'd9, 16'd0});
      write_csr(CSR_WANTED_B, {16'h0100, 16'd4, 16'd0});
      write_csr(CSR_WANTED_C, {16'h0200, 16'd0, 16'd0});
      write_csr(CSR_WANTED_D, {16'h0300, 16'd13, 16'd0});
      write_csr(CSR_PAST_END, 48'hffff_ffff_ffff);
      send_logical(1'b1, 16'h0100, 16'd9, 32'd1, 32'h0a0b_0c0d);
      send_logical(1'b0, 16'h0100, 16'd4, 32'd1, 32'h0);
      send_logical(1'b0, 16'h0200, 16'd0, 32'd1, 32'h0);
      send_logical(1'b0, 16'h0300, 16'd13, 32'd1, 32'h0);
      send_logical(1'b0, 16'h0100, 16'd9, 32'd3, 32'h8000_0001);
      send_logical(1'b0, 16'h0100, 16'd9, 32'h0000_fffe, 32'h0000_0040);
      wait_drained();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: write_random_config(1'b0, 16'h0000, 3'd4);
            1: write_random_config(1'b1, 16'hffff, 3'd7);
            2: write_random_config(1'($urandom), 16'($urandom), 3'd0);
            default: write_random_config(1'($urandom), 16'($urandom),
                                         3'($urandom_range(1, 7)));
         endcase
         idle_enable = (phase != 3);
         if (phase == 5) hold_request = 1'b1;
         repeat (ITEMS_PER_PHASE) send_random_entry(1'b1);
         wait_drained();
      end

      if (sb.errors == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
